FILE: rtl/core/brrf_pkg.sv
`timescale 1ns / 1ps

package brrf_pkg;

    localparam int MAX_WIDTH = 64;
    localparam int ROW_BITS  = 16;
    localparam int COL_BITS  = $clog2(MAX_WIDTH);
    localparam int CNT_BITS  = COL_BITS + 1;
    localparam int CFG_BITS  = 7;
    localparam int HGT_BITS  = ROW_BITS + 1;
    localparam int Q_DEPTH   = 2;
    localparam int Q_BITS    = $clog2(Q_DEPTH);
    localparam int QCNT_BITS = $clog2(Q_DEPTH + 1);

    localparam logic [CFG_BITS-1:0] WIDTH_RESET = CFG_BITS'(MAX_WIDTH);

    // One rectangle job: the run pattern of a closed chunk and its row span.
    typedef struct packed {
        logic [MAX_WIDTH-1:0] bits;
        logic [ROW_BITS-1:0]  top;
        logic [ROW_BITS-1:0]  bottom;
        logic                 last_job;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } t_back_state;

endpackage

FILE: rtl/core/brrf_front.sv
`timescale 1ns / 1ps

module brrf_front import brrf_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_pixel,
    input  logic                i_last_of_image,
    input  logic                i_cfg_we,
    input  logic [CFG_BITS-1:0] i_cfg_data,
    output logic                o_push,
    output t_job                o_job,
    input  t_q_status           i_q
);

    logic [CFG_BITS-1:0]  r_row_width;
    logic [MAX_WIDTH-1:0] r_cur, n_cur;
    logic [MAX_WIDTH-1:0] r_ref, n_ref;
    logic [COL_BITS-1:0]  r_col, n_col;
    logic [ROW_BITS-1:0]  r_row, n_row;
    logic [ROW_BITS-1:0]  r_start, n_start;
    logic                 r_open, n_open;
    logic                 r_pa_vld, n_pa_vld;
    logic                 r_pb_vld, n_pb_vld;
    t_job                 r_ja, n_ja;
    t_job                 r_jb, n_jb;

    logic [CFG_BITS-1:0]  w_eff;
    logic [MAX_WIDTH-1:0] mask;
    logic [MAX_WIDTH-1:0] cur_set;
    logic [MAX_WIDTH-1:0] curm;
    logic [MAX_WIDTH-1:0] refm;
    logic                 accept;
    logic                 row_done;
    logic                 differ;
    logic                 open1;
    logic                 open2;
    logic                 has_b;

    always_comb begin
        if (r_row_width == '0) begin
            w_eff = CFG_BITS'(1);
        end else if (r_row_width > CFG_BITS'(MAX_WIDTH)) begin
            w_eff = CFG_BITS'(MAX_WIDTH);
        end else begin
            w_eff = r_row_width;
        end
        for (int i = 0; i < MAX_WIDTH; i++) begin
            mask[i] = (CFG_BITS'(i) < w_eff);
        end
    end

    assign o_stall  = r_pa_vld | r_pb_vld;
    assign accept   = i_valid && !o_stall;
    assign cur_set  = r_cur | (MAX_WIDTH'(i_pixel) << r_col);
    assign row_done = i_last_of_image || !((CFG_BITS'(r_col) + CFG_BITS'(1)) < w_eff);
    assign curm     = cur_set & mask;
    assign refm     = r_ref & mask;
    assign differ   = r_open && (curm != refm);
    assign open1    = r_open && !differ;
    assign open2    = open1 || (curm != '0);
    assign has_b    = i_last_of_image && open2;

    assign o_push = o_stall && !i_q.full;
    assign o_job  = r_pa_vld ? r_ja : r_jb;

    always_comb begin
        n_cur    = r_cur;
        n_ref    = r_ref;
        n_col    = r_col;
        n_row    = r_row;
        n_start  = r_start;
        n_open   = r_open;
        n_pa_vld = r_pa_vld;
        n_pb_vld = r_pb_vld;
        n_ja     = r_ja;
        n_jb     = r_jb;

        // Pending jobs drain into the queue one per cycle while it is not full, the older first.
        if (o_push) begin
            if (r_pa_vld) begin
                n_pa_vld = 1'b0;
            end else begin
                n_pb_vld = 1'b0;
            end
        end

        if (accept) begin
            if (!row_done) begin
                n_cur = cur_set;
                n_col = r_col + COL_BITS'(1);
            end else begin
                n_cur = '0;
                n_col = '0;
                // The old chunk closes on a differing row, bottom is the row before.
                n_pa_vld = differ;
                n_ja     = '{bits: refm, top: r_start, bottom: r_row - ROW_BITS'(1),
                             last_job: !has_b};
                n_pb_vld = has_b;
                n_jb     = '{bits: open1 ? refm : curm, top: open1 ? r_start : r_row,
                             bottom: r_row, last_job: 1'b1};
                if (!open1 && (curm != '0)) begin
                    n_ref   = curm;
                    n_start = r_row;
                end
                if (i_last_of_image) begin
                    n_open = 1'b0;
                    n_row  = '0;
                end else begin
                    n_open = open2;
                    n_row  = r_row + ROW_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= WIDTH_RESET;
            r_cur       <= '0;
            r_ref       <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_start     <= '0;
            r_open      <= 1'b0;
            r_pa_vld    <= 1'b0;
            r_pb_vld    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_row_width <= i_cfg_data;
            end
            r_cur    <= n_cur;
            r_ref    <= n_ref;
            r_col    <= n_col;
            r_row    <= n_row;
            r_start  <= n_start;
            r_open   <= n_open;
            r_pa_vld <= n_pa_vld;
            r_pb_vld <= n_pb_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ja <= n_ja;
        r_jb <= n_jb;
    end

endmodule

FILE: rtl/core/brrf_queue.sv
`timescale 1ns / 1ps

module brrf_queue import brrf_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_job      i_job,
    input  logic      i_pop,
    output t_job      o_job,
    output t_q_status o_q
);

    t_job                 r_mem [Q_DEPTH];
    logic [Q_BITS-1:0]    r_wp;
    logic [Q_BITS-1:0]    r_rp;
    logic [QCNT_BITS-1:0] r_cnt;

    assign o_job   = r_mem[r_rp];
    assign o_q.full  = (r_cnt == QCNT_BITS'(Q_DEPTH));
    assign o_q.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + Q_BITS'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + Q_BITS'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + QCNT_BITS'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - QCNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

`ifndef ASSERT_OFF
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_q.full)
        else $error("queue written while full");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_q.empty)
        else $error("queue read while empty");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCNT_BITS'(Q_DEPTH))
        else $error("queue count past its depth");
`endif

endmodule

FILE: rtl/core/brrf_back.sv
`timescale 1ns / 1ps

module brrf_back import brrf_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_job                i_job,
    input  t_q_status           i_q,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [COL_BITS-1:0] o_col_lo,
    output logic [ROW_BITS-1:0] o_top_row,
    output logic [COL_BITS-1:0] o_col_hi,
    output logic [ROW_BITS-1:0] o_bottom_row,
    output logic [CNT_BITS-1:0] o_rect_width,
    output logic [HGT_BITS-1:0] o_rect_height,
    output logic                o_last_of_burst
);

    t_back_state          r_state;
    logic [MAX_WIDTH-1:0] r_bits;
    logic [ROW_BITS-1:0]  r_top;
    logic [ROW_BITS-1:0]  r_bot;
    logic                 r_lastj;
    logic [CNT_BITS-1:0]  r_col;
    logic [COL_BITS-1:0]  r_start;
    logic                 r_in_run;
    logic                 r_o_vld;

    logic                 done;
    logic                 emit;
    logic                 can_load;
    logic                 step;
    logic [ROW_BITS-1:0]  span;

    // The pattern shifts right, so bit 0 is always the column under scan.
    assign done     = (r_bits == '0) && !r_in_run;
    assign emit     = r_in_run && !r_bits[0];
    assign can_load = !r_o_vld || !i_stall;
    assign step     = (r_state == ST_SCAN) && !done && (!emit || can_load);
    assign o_pop    = (r_state == ST_IDLE) && !i_q.empty;
    assign o_valid  = r_o_vld;
    // Row numbers wrap, so the span is taken at row width before it grows.
    assign span     = r_bot - r_top;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_in_run <= 1'b0;
            r_o_vld  <= 1'b0;
        end else begin
            if (emit && step) begin
                r_o_vld <= 1'b1;
            end else if (!i_stall) begin
                r_o_vld <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        r_state  <= ST_SCAN;
                        r_in_run <= 1'b0;
                    end
                end
                ST_SCAN: begin
                    if (done) begin
                        r_state <= ST_IDLE;
                    end else if (step) begin
                        if (r_bits[0]) begin
                            r_in_run <= 1'b1;
                        end else begin
                            r_in_run <= 1'b0;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_bits  <= i_job.bits;
            r_top   <= i_job.top;
            r_bot   <= i_job.bottom;
            r_lastj <= i_job.last_job;
            r_col   <= '0;
        end else if (step) begin
            r_bits <= r_bits >> 1;
            r_col  <= r_col + CNT_BITS'(1);
            if (r_bits[0] && !r_in_run) begin
                r_start <= r_col[COL_BITS-1:0];
            end
        end
        if (emit && step) begin
            o_col_lo        <= r_start;
            o_top_row       <= r_top;
            o_col_hi        <= COL_BITS'(r_col - CNT_BITS'(1));
            o_bottom_row    <= r_bot;
            o_rect_width    <= r_col - CNT_BITS'(r_start);
            o_rect_height   <= HGT_BITS'(span) + HGT_BITS'(1);
            o_last_of_burst <= r_lastj && (r_bits == '0);
        end
    end

`ifndef ASSERT_OFF
    // A run that reaches the last column is closed one step past the row end.
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_col <= CNT_BITS'(MAX_WIDTH + 1)))
        else $error("scan column past row end");
    a_rect_from_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_vld) |-> $past(r_state == ST_SCAN))
        else $error("rectangle produced outside a scan");
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_col_lo) && $stable(o_col_hi)
                                  && $stable(o_top_row) && $stable(o_bottom_row)
                                  && $stable(o_last_of_burst)))
        else $error("stalled rectangle changed");
`endif

endmodule

FILE: rtl/core/binary_raster_rectangle_finder.sv
`timescale 1ns / 1ps

// Binary raster rectangle finder. Pixels arrive one per cycle in row order and
// are taken at one per cycle while the input is not stalled; a row that closes a
// chunk of identical rows raises one rectangle job, or two when the image ends on
// a differing row that has set pixels, and stalls the input until its jobs have
// entered the queue. Each job waits in a two-entry queue and is drained by a
// scanner that walks the row pattern one column per cycle while the output is not
// stalled, and a job holds the scanner until its last run of ones is closed;
// rectangles leave through a registered output. The front stalls whenever a job
// is still pending. The user must write row_width only while the block is idle;
// the block does not enforce this. 0 acts as 1 and values above 64 act as 64.
module binary_raster_rectangle_finder import brrf_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_pixel,
    input  logic                i_last_of_image,
    input  logic                i_cfg_we,
    input  logic [CFG_BITS-1:0] i_cfg_data,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [COL_BITS-1:0] o_col_lo,
    output logic [ROW_BITS-1:0] o_top_row,
    output logic [COL_BITS-1:0] o_col_hi,
    output logic [ROW_BITS-1:0] o_bottom_row,
    output logic [CNT_BITS-1:0] o_rect_width,
    output logic [HGT_BITS-1:0] o_rect_height,
    output logic                o_last_of_burst
);

    logic      push;
    logic      pop;
    t_job      push_job;
    t_job      head_job;
    t_q_status q_status;

    brrf_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_pixel         (i_pixel),
        .i_last_of_image (i_last_of_image),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .o_push          (push),
        .o_job           (push_job),
        .i_q             (q_status)
    );

    brrf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_q     (q_status)
    );

    brrf_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job           (head_job),
        .i_q             (q_status),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_col_lo        (o_col_lo),
        .o_top_row       (o_top_row),
        .o_col_hi        (o_col_hi),
        .o_bottom_row    (o_bottom_row),
        .o_rect_width    (o_rect_width),
        .o_rect_height   (o_rect_height),
        .o_last_of_burst (o_last_of_burst)
    );

endmodule
